[src/gce_pkg.sv]
`default_nettype none

package gce_pkg;

    // default sizes of the table and of a model
    localparam int MAX_SLOTS_DEF     = 8;
    localparam int MAX_GROUPS_DEF    = 64;
    localparam int MAX_GROUP_LEN_DEF = 16;

    // depth of the command queue between front and back
    localparam int Q_DEPTH = 2;

    // input word kinds
    localparam logic [1:0] KIND_SIZE    = 2'd0;
    localparam logic [1:0] KIND_ITEM    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;
    localparam logic [1:0] KIND_STEP    = 2'd3;

    // queued command opcodes
    localparam logic [2:0] OP_SIZE    = 3'd0;
    localparam logic [2:0] OP_ITEM    = 3'd1;
    localparam logic [2:0] OP_RESTART = 3'd2;
    localparam logic [2:0] OP_STEP    = 3'd3;
    localparam logic [2:0] OP_ERROR   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_ELEM = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_MODEL_SIZE   = 3'd0;
    localparam logic [2:0] CFG_GROUP_COUNT  = 3'd1;
    localparam logic [2:0] CFG_FIXED_GROUPS = 3'd2;
    localparam logic [2:0] CFG_FIXED_ITEMS  = 3'd3;
    localparam logic [2:0] CFG_SKIP_EMPTY   = 3'd4;
    localparam logic [2:0] CFG_TARGET_COUNT = 3'd5;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  group;
        logic [3:0]  position;
        logic [15:0] value;
    } t_cmd;

endpackage

`default_nettype wire

[src/gce_channels.sv]
`default_nettype none

interface gce_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  group;
    logic [3:0]  position;
    logic [15:0] value;

    modport source (output valid, kind, group, position, value, input ready);
    modport sink (input valid, kind, group, position, value, output ready);
endinterface

interface gce_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [15:0] item;
    logic        last;

    modport source (output valid, status, slot, item, last, input ready);
    modport sink (input valid, status, slot, item, last, output ready);
endinterface

interface gce_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/gce_ram.sv]
`default_nettype none

module gce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/gce_front.sv]
`default_nettype none

module gce_front #(
    parameter int MAX_GROUPS    = gce_pkg::MAX_GROUPS_DEF,
    parameter int MAX_GROUP_LEN = gce_pkg::MAX_GROUP_LEN_DEF
) (
    gce_in_if.sink              i_in,
    input  wire logic           i_full,
    output logic                o_push,
    output gce_pkg::t_cmd       o_cmd
);

    logic group_bad;
    logic pos_bad;

    assign group_bad = 32'(i_in.group) >= 32'(MAX_GROUPS);
    assign pos_bad   = 32'(i_in.position) >= 32'(MAX_GROUP_LEN);

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_cmd.group    = i_in.group;
        o_cmd.position = i_in.position;
        o_cmd.value    = i_in.value;
        case (i_in.kind)
            gce_pkg::KIND_SIZE: begin
                o_cmd.op = group_bad ? gce_pkg::OP_ERROR : gce_pkg::OP_SIZE;
                // sizes saturate at the group length
                if (32'(i_in.value) > 32'(MAX_GROUP_LEN)) begin
                    o_cmd.value = 16'(MAX_GROUP_LEN);
                end
            end
            gce_pkg::KIND_ITEM: begin
                o_cmd.op = (group_bad || pos_bad) ? gce_pkg::OP_ERROR : gce_pkg::OP_ITEM;
            end
            gce_pkg::KIND_RESTART: begin
                o_cmd.op = gce_pkg::OP_RESTART;
            end
            default: begin
                o_cmd.op = gce_pkg::OP_STEP;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/gce_fifo.sv]
`default_nettype none

module gce_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  gce_pkg::t_cmd      i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output gce_pkg::t_cmd      o_data,
    output logic               o_empty
);

    localparam int PW = gce_pkg::Q_DEPTH > 1 ? $clog2(gce_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(gce_pkg::Q_DEPTH + 1);

    gce_pkg::t_cmd r_mem [gce_pkg::Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;

    assign o_full  = r_cnt == CW'(gce_pkg::Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];

    assign n_wp = (r_wp == PW'(gce_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == PW'(gce_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

[src/gce_back.sv]
`default_nettype none

module gce_back #(
    parameter int MAX_SLOTS     = gce_pkg::MAX_SLOTS_DEF,
    parameter int MAX_GROUPS    = gce_pkg::MAX_GROUPS_DEF,
    parameter int MAX_GROUP_LEN = gce_pkg::MAX_GROUP_LEN_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  gce_pkg::t_cmd      i_cmd,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    gce_cfg_if.sink            i_cfg,
    gce_out_if.source          o_out
);

    localparam int GW  = $clog2(MAX_GROUPS > MAX_SLOTS ? MAX_GROUPS : MAX_SLOTS);
    localparam int IW  = MAX_GROUP_LEN > 1 ? $clog2(MAX_GROUP_LEN) : 1;
    localparam int SW  = $clog2(MAX_GROUP_LEN + 1);
    localparam int XW  = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
    localparam int SAW = $clog2(MAX_GROUPS);
    localparam int IAW = $clog2(MAX_GROUPS * MAX_GROUP_LEN);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIG_RD = 4'd1;
    localparam logic [3:0] S_DIG    = 4'd2;
    localparam logic [3:0] S_P0_RD  = 4'd3;
    localparam logic [3:0] S_P0     = 4'd4;
    localparam logic [3:0] S_GRP    = 4'd5;
    localparam logic [3:0] S_ZRD    = 4'd6;
    localparam logic [3:0] S_ZCHK   = 4'd7;
    localparam logic [3:0] S_SKRD   = 4'd8;
    localparam logic [3:0] S_SK     = 4'd9;
    localparam logic [3:0] S_ERD    = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;
    localparam logic [3:0] S_SINGLE = 4'd12;

    // configuration
    logic [3:0]  r_k;
    logic [6:0]  r_n;
    logic [3:0]  r_f;
    logic [15:0] r_fi;
    logic        r_skip;
    logic [15:0] r_tc;

    // enumeration state
    logic [GW-1:0] r_gc    [MAX_SLOTS];
    logic [GW-1:0] n_gc    [MAX_SLOTS];
    logic [IW-1:0] r_inner [MAX_SLOTS];
    logic [IW-1:0] n_inner [MAX_SLOTS];
    logic          r_started, n_started;
    logic          r_finished, n_finished;

    // sequencer
    logic [3:0]    r_state, n_state;
    logic [XW-1:0] r_idx, n_idx;
    logic          r_from_grp, n_from_grp;
    logic          r_filter, n_filter;
    logic [1:0]    r_stat, n_stat;

    // output register
    logic          r_ov, n_ov;
    logic [1:0]    r_ostat, n_ostat;
    logic [2:0]    r_oslot, n_oslot;
    logic [15:0]   r_oitem, n_oitem;
    logic          r_olast, n_olast;
    logic          ld_out;

    // memories
    logic           size_we;
    logic [SAW-1:0] size_waddr;
    logic [SAW-1:0] size_raddr;
    logic [SW-1:0]  size_rd;
    logic           item_we;
    logic [IAW-1:0] item_waddr;
    logic [IAW-1:0] item_raddr;
    logic [15:0]    item_rd;
    logic [XW-1:0]  rd_slot;

    logic          cfg_bad;
    logic          gc_bad;
    logic          found;
    logic [XW-1:0] jsel;
    logic [GW-1:0] grp_gc [MAX_SLOTS];
    logic          dig_inc;
    logic          idx_last;
    logic          p0_pass;
    logic          can_emit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= 4'd1;
            r_n    <= 7'd1;
            r_f    <= '0;
            r_fi   <= '0;
            r_skip <= 1'b0;
            r_tc   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                gce_pkg::CFG_MODEL_SIZE:   r_k    <= i_cfg.data[3:0];
                gce_pkg::CFG_GROUP_COUNT:  r_n    <= i_cfg.data[6:0];
                gce_pkg::CFG_FIXED_GROUPS: r_f    <= i_cfg.data[3:0];
                gce_pkg::CFG_FIXED_ITEMS:  r_fi   <= i_cfg.data;
                gce_pkg::CFG_SKIP_EMPTY:   r_skip <= i_cfg.data[0];
                gce_pkg::CFG_TARGET_COUNT: r_tc   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // slot-0 test always reads slot 0; everything else reads the current slot
    assign rd_slot    = (r_state == S_P0_RD) ? '0 : r_idx;
    assign size_raddr = r_gc[rd_slot][SAW-1:0];
    assign item_raddr = IAW'(32'(r_gc[rd_slot]) * 32'(MAX_GROUP_LEN) + 32'(r_inner[rd_slot]));

    assign o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;
    assign size_we    = o_cmd_pop && (i_cmd.op == gce_pkg::OP_SIZE);
    assign item_we    = o_cmd_pop && (i_cmd.op == gce_pkg::OP_ITEM);
    assign size_waddr = SAW'(i_cmd.group);
    assign item_waddr = IAW'(32'(i_cmd.group) * 32'(MAX_GROUP_LEN) + 32'(i_cmd.position));

    gce_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_GROUPS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size_we),
        .i_waddr (size_waddr),
        .i_wdata (SW'(i_cmd.value)),
        .i_raddr (size_raddr),
        .o_rdata (size_rd)
    );

    gce_ram #(
        .WIDTH (16),
        .DEPTH (MAX_GROUPS * MAX_GROUP_LEN)
    ) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (item_we),
        .i_waddr (item_waddr),
        .i_wdata (i_cmd.value),
        .i_raddr (item_raddr),
        .o_rdata (item_rd)
    );

    assign cfg_bad = (r_k == '0) || (32'(r_k) > 32'(MAX_SLOTS)) || (r_n < 7'(r_k))
                     || (32'(r_n) > 32'(MAX_GROUPS)) || (r_f > r_k);

    always_comb begin
        gc_bad = 1'b0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if ((5'(i) < 5'(r_k)) && (9'(r_gc[i]) >= 9'(r_n))) begin
                gc_bad = 1'b1;
            end
        end
    end

    // rightmost free slot whose group can still move up
    always_comb begin
        found = 1'b0;
        jsel  = '0;
        for (int j = 0; j < MAX_SLOTS; j++) begin
            if ((5'(j) >= 5'(r_f)) && (5'(j) < 5'(r_k))
                && (9'(r_gc[j]) < 9'(r_n) - 9'(r_k) + 9'(j))) begin
                found = 1'b1;
                jsel  = XW'(j);
            end
        end
        for (int i = 0; i < MAX_SLOTS; i++) begin
            grp_gc[i] = r_gc[i];
            if ((5'(i) >= 5'(jsel)) && (5'(i) < 5'(r_k))) begin
                grp_gc[i] = GW'(9'(r_gc[jsel]) + 9'(i) - 9'(jsel) + 9'd1);
            end
        end
    end

    assign dig_inc  = (8'(r_inner[r_idx]) + 8'd1) < 8'(size_rd);
    assign idx_last = (5'(r_idx) + 5'd1) == 5'(r_k);
    assign p0_pass  = (8'(size_rd) > 8'(r_inner[0])) && (item_rd < r_fi);
    assign can_emit = !r_ov || o_out.ready;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_from_grp = r_from_grp;
        n_filter   = r_filter;
        n_stat     = r_stat;
        n_started  = r_started;
        n_finished = r_finished;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            n_gc[i]    = r_gc[i];
            n_inner[i] = r_inner[i];
        end
        ld_out  = 1'b0;
        n_ostat = r_ostat;
        n_oslot = r_oslot;
        n_oitem = r_oitem;
        n_olast = r_olast;

        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.op)
                        gce_pkg::OP_SIZE, gce_pkg::OP_ITEM: ;
                        gce_pkg::OP_RESTART: begin
                            for (int i = 0; i < MAX_SLOTS; i++) begin
                                n_gc[i]    = GW'(i);
                                n_inner[i] = '0;
                            end
                            n_started  = 1'b0;
                            n_finished = 1'b0;
                        end
                        gce_pkg::OP_STEP: begin
                            n_idx = '0;
                            if (cfg_bad || gc_bad) begin
                                n_stat  = gce_pkg::ST_ERR;
                                n_state = S_SINGLE;
                            end else if (r_finished) begin
                                n_stat  = gce_pkg::ST_DONE;
                                n_state = S_SINGLE;
                            end else if (!r_started) begin
                                // first model goes out unfiltered
                                n_started = 1'b1;
                                n_filter  = 1'b0;
                                n_state   = S_ZRD;
                            end else begin
                                n_filter = 1'b1;
                                n_state  = S_DIG_RD;
                            end
                        end
                        default: begin
                            n_stat  = gce_pkg::ST_ERR;
                            n_state = S_SINGLE;
                        end
                    endcase
                end
            end
            S_DIG_RD: begin
                n_state = S_DIG;
            end
            S_DIG: begin
                if (dig_inc) begin
                    n_inner[r_idx] = r_inner[r_idx] + 1'b1;
                    if (r_fi == '0) begin
                        n_idx   = '0;
                        n_state = S_ZRD;
                    end else begin
                        n_from_grp = 1'b0;
                        n_state    = S_P0_RD;
                    end
                end else begin
                    n_inner[r_idx] = '0;
                    if (idx_last) begin
                        n_state = S_GRP;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_DIG_RD;
                    end
                end
            end
            S_P0_RD: begin
                n_state = S_P0;
            end
            S_P0: begin
                if (p0_pass) begin
                    n_idx   = '0;
                    n_state = S_ZRD;
                end else if (r_from_grp) begin
                    n_finished = 1'b1;
                    n_stat     = gce_pkg::ST_DONE;
                    n_state    = S_SINGLE;
                end else begin
                    // failed digit advance resets and carries on
                    n_inner[r_idx] = '0;
                    if (idx_last) begin
                        n_state = S_GRP;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_DIG_RD;
                    end
                end
            end
            S_GRP: begin
                if (!found) begin
                    n_finished = 1'b1;
                    n_stat     = gce_pkg::ST_DONE;
                    n_state    = S_SINGLE;
                end else begin
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        n_gc[i] = grp_gc[i];
                    end
                    n_idx = '0;
                    if (r_fi == '0) begin
                        n_state = S_ZRD;
                    end else begin
                        n_from_grp = 1'b1;
                        n_state    = S_P0_RD;
                    end
                end
            end
            S_ZRD: begin
                n_state = S_ZCHK;
            end
            S_ZCHK: begin
                if (size_rd == '0) begin
                    n_stat  = gce_pkg::ST_ERR;
                    n_state = S_SINGLE;
                end else if (idx_last) begin
                    n_idx   = '0;
                    n_state = S_SKRD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_ZRD;
                end
            end
            S_SKRD: begin
                n_state = (r_filter && r_skip) ? S_SK : S_ERD;
            end
            S_SK: begin
                // empty model: step ends with no word
                n_state = (item_rd >= r_tc) ? S_IDLE : S_ERD;
            end
            S_ERD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (can_emit) begin
                    ld_out  = 1'b1;
                    n_ostat = gce_pkg::ST_ELEM;
                    n_oslot = 3'(r_idx);
                    n_oitem = item_rd;
                    n_olast = idx_last;
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_ERD;
                    end
                end
            end
            S_SINGLE: begin
                if (can_emit) begin
                    ld_out  = 1'b1;
                    n_ostat = r_stat;
                    n_oslot = '0;
                    n_oitem = '0;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ld_out) begin
            n_ov = 1'b1;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_from_grp <= 1'b0;
            r_filter   <= 1'b0;
            r_stat     <= gce_pkg::ST_ELEM;
            r_started  <= 1'b0;
            r_finished <= 1'b0;
            r_ov       <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_gc[i]    <= GW'(i);
                r_inner[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_from_grp <= n_from_grp;
            r_filter   <= n_filter;
            r_stat     <= n_stat;
            r_started  <= n_started;
            r_finished <= n_finished;
            r_ov       <= n_ov;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_gc[i]    <= n_gc[i];
                r_inner[i] <= n_inner[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ostat <= n_ostat;
        r_oslot <= n_oslot;
        r_oitem <= n_oitem;
        r_olast <= n_olast;
    end

    assign o_out.valid  = r_ov;
    assign o_out.status = r_ostat;
    assign o_out.slot   = r_oslot;
    assign o_out.item   = r_oitem;
    assign o_out.last   = r_olast;

`ifndef NO_ASSERTIONS
    a_fin_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> r_started)
        else $error("finished set without a started enumeration");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && can_emit) |-> (5'(r_idx) < 5'(r_k)))
        else $error("element word for a slot beyond model size");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && n_olast) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final word of a step");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> !(size_we || item_we) || $past(r_state == S_IDLE)
            || (r_state == S_IDLE))
        else $error("table written outside idle");
`endif

endmodule

`default_nettype wire

[src/grouped_combination_enumerator_core.sv]
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    kind, group, position, value
// o_out     out  valid/ready    status, slot, item, last
// i_cfg     in   valid/ready    index, data (ready always high)
//
// Loads and restart are done in the back end's idle state once at the queue head.
// A step visits d digits, runs p slot-0 tests, makes at most one group move
// (g), then checks and emits the k slots (k model size); each table has a
// single read port, so every lookup is a read state then a use state.
// Reset: synchronous, active low; tables are not cleared.
// A stalled output holds one word; the front keeps accepting until the
// two-word queue fills.
`default_nettype none

module grouped_combination_enumerator_core #(
    parameter int MAX_SLOTS     = gce_pkg::MAX_SLOTS_DEF,
    parameter int MAX_GROUPS    = gce_pkg::MAX_GROUPS_DEF,
    parameter int MAX_GROUP_LEN = gce_pkg::MAX_GROUP_LEN_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gce_in_if.sink     i_in,
    gce_out_if.source  o_out,
    gce_cfg_if.sink    i_cfg
);

    gce_pkg::t_cmd push_cmd;
    gce_pkg::t_cmd head_cmd;
    logic          push;
    logic          full;
    logic          pop;
    logic          empty;

    gce_front #(
        .MAX_GROUPS    (MAX_GROUPS),
        .MAX_GROUP_LEN (MAX_GROUP_LEN)
    ) u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    gce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (empty)
    );

    gce_back #(
        .MAX_SLOTS     (MAX_SLOTS),
        .MAX_GROUPS    (MAX_GROUPS),
        .MAX_GROUP_LEN (MAX_GROUP_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (empty),
        .o_cmd_pop   (pop),
        .i_cfg       (i_cfg),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

[tb/tb_grouped_combination_enumerator_core.sv]
`timescale 1ns / 1ps

module tb_grouped_combination_enumerator_core;
    import gce_pkg::*;

    localparam int NSLOT         = MAX_SLOTS_DEF;
    localparam int NGRP          = MAX_GROUPS_DEF;
    localparam int GLEN          = MAX_GROUP_LEN_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 250;
    localparam int RANDOM_WORDS  = 260;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [15:0] item;
        logic        last;
    } out_word_t;

    logic i_clk;
    logic i_rst_n;

    gce_in_if  in_ch ();
    gce_out_if out_ch ();
    gce_cfg_if cfg_ch ();

    grouped_combination_enumerator_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // mirror of the table, the walk position and the registers
    int          tbl_size [NGRP];
    logic [15:0] tbl_item [NGRP*GLEN];
    int          sel_group [NSLOT];
    int          sel_pos [NSLOT];
    bit          has_started;
    bit          has_finished;
    logic [3:0]  cfg_k;
    logic [6:0]  cfg_n;
    logic [3:0]  cfg_f;
    logic [15:0] cfg_fi;
    logic        cfg_skip;
    logic [15:0] cfg_tc;

    // which table entries the stimulus has written so far
    bit size_known [NGRP];
    bit item_known [NGRP*GLEN];

    out_word_t pending_words [$];

    int cycles;
    int mismatches;
    int words_seen;
    int done_seen;
    int err_seen;
    int items_sent;
    int steps_sent;
    int phases;
    bit idle_on;
    int rx_wait;
    int rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- mirror

    function automatic void push_word(logic [1:0] st, int slot, logic [15:0] item, bit last);
        out_word_t w;
        w.status = st;
        w.slot   = slot[2:0];
        w.item   = item;
        w.last   = last;
        pending_words.push_back(w);
    endfunction

    function automatic void restart_walk();
        int i;
        for (i = 0; i < NSLOT; i++) begin
            sel_group[i] = i;
            sel_pos[i]   = 0;
        end
        has_started  = 1'b0;
        has_finished = 1'b0;
    endfunction

    function automatic int size_of(int g);
        return (g < NGRP) ? tbl_size[g] : 0;
    endfunction

    function automatic logic [15:0] item_of(int g, int p);
        if (g >= NGRP || p >= GLEN) return 16'd0;
        return tbl_item[g*GLEN + p];
    endfunction

    function automatic bit slot0_ok();
        int g0;
        g0 = sel_group[0];
        if (size_of(g0) <= sel_pos[0]) return 1'b0;
        return item_of(g0, sel_pos[0]) < cfg_fi;
    endfunction

    // one move of the digit counter, then of the combination; 0 when exhausted or when slot 0 fails after a group move
    function automatic bit advance_model();
        int i, k, n, f, free_slot;
        k = cfg_k;
        n = cfg_n;
        f = cfg_f;
        for (i = 0; i < k; i++) begin
            if (sel_pos[i] + 1 < size_of(sel_group[i])) begin
                sel_pos[i]++;
                if (cfg_fi == 0 || slot0_ok()) return 1'b1;
            end
            sel_pos[i] = 0;
        end
        free_slot = k;
        while (free_slot > f) begin
            if (sel_group[free_slot-1] < n - (k - free_slot) - 1) break;
            free_slot--;
        end
        if (free_slot == f) return 1'b0;
        sel_group[free_slot-1]++;
        for (i = free_slot; i < k; i++)
            sel_group[i] = sel_group[i-1] + 1;
        return cfg_fi == 0 || slot0_ok();
    endfunction

    function automatic void emit_words();
        int i, k;
        k = cfg_k;
        for (i = 0; i < k; i++) begin
            if (size_of(sel_group[i]) == 0) begin
                push_word(ST_ERR, 0, 16'd0, 1'b1);
                return;
            end
        end
        if (has_started && cfg_skip && item_of(sel_group[0], sel_pos[0]) >= cfg_tc)
            return;
        for (i = 0; i < k; i++)
            push_word(ST_ELEM, i, item_of(sel_group[i], sel_pos[i]), i + 1 == k);
    endfunction

    function automatic void step_model();
        int i, k, n, f;
        bit bad;
        k = cfg_k;
        n = cfg_n;
        f = cfg_f;
        bad = (k == 0) || (k > NSLOT) || (n < k) || (n > NGRP) || (f > k);
        if (!bad) begin
            for (i = 0; i < k; i++)
                if (sel_group[i] >= n) bad = 1'b1;
        end
        if (bad) begin
            push_word(ST_ERR, 0, 16'd0, 1'b1);
        end else if (has_finished) begin
            push_word(ST_DONE, 0, 16'd0, 1'b1);
        end else if (!has_started) begin
            emit_words();
            has_started = 1'b1;
        end else if (!advance_model()) begin
            has_finished = 1'b1;
            push_word(ST_DONE, 0, 16'd0, 1'b1);
        end else begin
            emit_words();
        end
    endfunction

    function automatic void next_model_words(logic [1:0] kind, logic [5:0] grp,
                                             logic [3:0] pos, logic [15:0] val);
        case (kind)
            KIND_SIZE:    tbl_size[grp] = (val > GLEN) ? GLEN : int'(val);
            KIND_ITEM:    tbl_item[int'(grp)*GLEN + int'(pos)] = val;
            KIND_RESTART: restart_walk();
            default:      step_model();
        endcase
    endfunction

    function automatic logic [15:0] rand_item();
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 15));
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_word(logic [1:0] kind, logic [5:0] grp, logic [3:0] pos,
                             logic [15:0] val);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= kind;
        in_ch.group    <= grp;
        in_ch.position <= pos;
        in_ch.value    <= val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        next_model_words(kind, grp, pos, val);
        items_sent++;
        if (kind == KIND_STEP) steps_sent++;
    endtask

    task automatic send_step();
        send_word(KIND_STEP, 6'($urandom), 4'($urandom), 16'($urandom));
    endtask

    task automatic send_restart();
        send_word(KIND_RESTART, 6'($urandom), 4'($urandom), 16'($urandom));
    endtask

    task automatic load_item(int g, int p, logic [15:0] v);
        send_word(KIND_ITEM, g[5:0], p[3:0], v);
        item_known[g*GLEN + p] = 1'b1;
    endtask

    // size load, followed by every item within the new size not yet written
    task automatic load_size(int g, logic [15:0] v);
        int s, p;
        send_word(KIND_SIZE, g[5:0], 4'($urandom), v);
        size_known[g] = 1'b1;
        s = (v > GLEN) ? GLEN : int'(v);
        for (p = 0; p < s; p++)
            if (!item_known[g*GLEN + p]) load_item(g, p, rand_item());
    endtask

    task automatic ensure_groups(int n);
        int g, top;
        top = (n > NGRP) ? NGRP : n;
        for (g = 0; g < top; g++) begin
            if (!size_known[g])
                load_size(g, ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 2)));
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    // steps that emit nothing may still be in flight after the last word
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_MODEL_SIZE:   cfg_k    = data[3:0];
            CFG_GROUP_COUNT:  cfg_n    = data[6:0];
            CFG_FIXED_GROUPS: cfg_f    = data[3:0];
            CFG_FIXED_ITEMS:  cfg_fi   = data;
            CFG_SKIP_EMPTY:   cfg_skip = data[0];
            CFG_TARGET_COUNT: cfg_tc   = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(int k, int n, int f, int fi, int se, int tc);
        ensure_groups(n);
        settle();
        // unused upper bits carry noise
        cfg_write(CFG_MODEL_SIZE,   (16'($urandom) & 16'hFFF0) | 16'(k & 15));
        cfg_write(CFG_GROUP_COUNT,  (16'($urandom) & 16'hFF80) | 16'(n & 127));
        cfg_write(CFG_FIXED_GROUPS, (16'($urandom) & 16'hFFF0) | 16'(f & 15));
        cfg_write(CFG_FIXED_ITEMS,  16'(fi));
        cfg_write(CFG_SKIP_EMPTY,   (16'($urandom) & 16'hFFFE) | 16'(se & 1));
        cfg_write(CFG_TARGET_COUNT, 16'(tc));
        phases++;
    endtask

    // ---------------------------------------------------------------- checker

    always @(posedge i_clk) begin
        out_word_t got;
        out_word_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.status, out_ch.slot, out_ch.item, out_ch.last};
            rx_wait = idle_on ? $urandom_range(0, 3) : 0;
            words_seen++;
            if (got.status == ST_DONE) done_seen++;
            if (got.status == ST_ERR) err_seen++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d slot %0d item %0h last %0d",
                             got.status, got.slot, got.item, got.last);
            end else begin
                want = pending_words.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.item !== want.item || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at word %0d (exp/got): status %0d/%0d ",
                                  "slot %0d/%0d item %0h/%0h last %0d/%0d"},
                                 words_seen, want.status, got.status, want.slot, got.slot,
                                 want.item, got.item, want.last, got.last);
                end
            end
        end
    end

    // output ready: per-word random wait, plus a long hold when asked
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold--;
            end else if (rx_wait > 0) begin
                out_ch.ready <= 1'b0;
                rx_wait--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d words still expected",
                 cycles, pending_words.size());
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // first step straight out of reset, a full walk to done, done repeated
    task automatic test_basic_walk();
        idle_on = 1'b1;
        load_size(0, 16'd1);
        send_step();
        send_step();
        send_step();
        load_size(0, 16'd2);
        load_size(1, 16'd1);
        load_size(2, 16'd2);
        load_size(3, 16'd1);
        set_config(2, 4, 0, 0, 0, 0);
        send_restart();
        repeat (15) send_step();
    endtask

    task automatic test_bad_config();
        load_size(0, 16'd1);
        load_size(1, 16'd1);
        load_size(2, 16'd1);
        set_config(0, 4, 0, 0, 0, 0);
        send_step();
        set_config(15, 4, 0, 0, 0, 0);
        send_step();
        set_config(3, 2, 0, 0, 0, 0);
        send_step();
        set_config(2, 127, 0, 0, 0, 0);
        send_step();
        set_config(2, 4, 15, 0, 0, 0);
        send_step();
        // walk to the last group, then shrink the group count below it
        set_config(1, 3, 0, 0, 0, 0);
        send_restart();
        repeat (4) send_step();
        set_config(1, 2, 0, 0, 0, 0);
        send_step();
        send_restart();
        send_step();
    endtask

    task automatic test_zero_size_group();
        load_size(1, 16'd0);
        set_config(2, 3, 0, 0, 0, 0);
        send_restart();
        repeat (6) send_step();
        set_config(1, 3, 0, 5, 0, 0);
        send_restart();
        repeat (5) send_step();
    endtask

    task automatic test_fixed_items();
        int g;
        for (g = 0; g < 5; g++) begin
            load_size(g, 16'd3);
            load_item(g, 0, 16'd1);
            load_item(g, 1, 16'd7);
            load_item(g, 2, 16'd4);
        end
        set_config(3, 5, 1, 5, 0, 0);
        send_restart();
        repeat (12) send_step();
    endtask

    task automatic test_skip_empty();
        set_config(2, 4, 0, 0, 1, 4);
        send_restart();
        repeat (12) send_step();
    endtask

    task automatic test_extremes();
        int g;
        for (g = 0; g < 8; g++) load_size(g, 16'd2);
        load_size(5, 16'hFFFF);
        load_item(5, 15, 16'hFFFF);
        load_item(6, 0, 16'h0000);
        set_config(8, 64, 8, 16'hFFFF, 1, 16'hFFFF);
        send_restart();
        repeat (6) send_step();
        set_config(1, 1, 1, 0, 0, 0);
        send_restart();
        repeat (3) send_step();
    endtask

    // receiver stalls long while the sender keeps offering steps
    task automatic test_backpressure();
        set_config(8, 8, 0, 0, 0, 0);
        send_restart();
        idle_on = 1'b0;
        rx_hold = 300;
        repeat (10) send_step();
        idle_on = 1'b1;
        drain_results();
        repeat (4) send_step();
    endtask

    task automatic test_random_traffic();
        int start_items, len, r, j, k, n, f, fi, tc;
        logic [15:0] sz;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_WORDS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                set_config($urandom_range(0, 15), $urandom_range(0, 127),
                           $urandom_range(0, 15), $urandom, $urandom_range(0, 1), $urandom);
            end else begin
                k  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, NSLOT)
                                                 : $urandom_range(1, 3);
                n  = ($urandom_range(0, 7) == 0) ? NGRP : $urandom_range(k, k + 5);
                f  = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, k);
                fi = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 16);
                tc = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 16);
                set_config(k, n, f, fi, $urandom_range(0, 1), tc);
            end
            send_restart();
            len = $urandom_range(15, 35);
            for (j = 0; j < len; j++) begin
                r = $urandom_range(0, 99);
                if (r < 72) begin
                    send_step();
                end else if (r < 76) begin
                    send_restart();
                end else if (r < 86) begin
                    load_item($urandom_range(0, NGRP-1), $urandom_range(0, GLEN-1),
                              rand_item());
                end else if (r < 96) begin
                    sz = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 4));
                    load_size(($urandom_range(0, 1) == 0) ? $urandom_range(0, 7)
                                                          : $urandom_range(0, NGRP-1), sz);
                end else begin
                    drain_results();
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- main

    initial begin
        int g;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.kind     = KIND_SIZE;
        in_ch.group    = '0;
        in_ch.position = '0;
        in_ch.value    = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_MODEL_SIZE;
        cfg_ch.data    = '0;
        for (g = 0; g < NGRP; g++) begin
            tbl_size[g]   = 0;
            size_known[g] = 1'b0;
        end
        for (g = 0; g < NGRP*GLEN; g++) begin
            tbl_item[g]   = '0;
            item_known[g] = 1'b0;
        end
        restart_walk();
        cfg_k      = 4'd1;
        cfg_n      = 7'd1;
        cfg_f      = 4'd0;
        cfg_fi     = 16'd0;
        cfg_skip   = 1'b0;
        cfg_tc     = 16'd0;
        mismatches = 0;
        words_seen = 0;
        done_seen  = 0;
        err_seen   = 0;
        items_sent = 0;
        steps_sent = 0;
        phases     = 0;
        idle_on    = 1'b1;
        rx_wait    = 0;
        rx_hold    = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_walk();
        test_bad_config();
        test_zero_size_group();
        test_fixed_items();
        test_skip_empty();
        test_extremes();
        test_backpressure();
        test_random_traffic();

        settle();
        if (pending_words.size() != 0) begin
            mismatches += pending_words.size();
            $display("%0d expected words never arrived", pending_words.size());
        end
        $display("covered %0d input words (%0d steps) over %0d register settings",
                 items_sent, steps_sent, phases);
        $display("checked %0d result words: %0d done, %0d error, %0d mismatches",
                 words_seen, done_seen, err_seen, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
src/gce_pkg.sv
src/gce_channels.sv
src/gce_ram.sv
src/gce_front.sv
src/gce_fifo.sv
src/gce_back.sv
src/grouped_combination_enumerator_core.sv
tb/tb_grouped_combination_enumerator_core.sv
